@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the serial command parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/scpr_pkg.sv @@
// ----------------------------------------------------------------------------
// scpr_pkg
// Types and constants of the serial command parser with reply queue.
// ----------------------------------------------------------------------------
`default_nettype none

package scpr_pkg;

   localparam int LEN_W   = 16;
   localparam int NUM_CSR = 6;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [1:0] RESULT_WRITE = 2'd0;
   localparam logic [1:0] RESULT_FETCH = 2'd1;
   localparam logic [1:0] RESULT_DROP  = 2'd2;

   localparam logic [1:0] TARGET_TABLE   = 2'd0;
   localparam logic [1:0] TARGET_SETTING = 2'd1;
   localparam logic [1:0] TARGET_X_AXIS  = 2'd2;
   localparam logic [1:0] TARGET_Y_AXIS  = 2'd3;

   localparam logic [2:0] SRC_REALTIME = 3'd0;
   localparam logic [2:0] SRC_SETTINGS = 3'd1;
   localparam logic [2:0] SRC_TABLE    = 3'd2;
   localparam logic [2:0] SRC_X_AXIS   = 3'd3;
   localparam logic [2:0] SRC_Y_AXIS   = 3'd4;
   localparam logic [2:0] SRC_ANALOG   = 3'd5;
   localparam logic [2:0] SRC_STATUS   = 3'd6;
   localparam logic [2:0] SRC_DEBUG    = 3'd7;

   localparam logic [2:0] CSR_REALTIME_LEN = 3'd0;
   localparam logic [2:0] CSR_SETTINGS_LEN = 3'd1;
   localparam logic [2:0] CSR_TABLE_LEN    = 3'd2;
   localparam logic [2:0] CSR_X_AXIS_LEN   = 3'd3;
   localparam logic [2:0] CSR_Y_AXIS_LEN   = 3'd4;
   localparam logic [2:0] CSR_ANALOG_CNT   = 3'd5;

   localparam logic [LEN_W-1:0] RESET_REALTIME_LEN = 16'd32;
   localparam logic [LEN_W-1:0] RESET_SETTINGS_LEN = 16'd64;
   localparam logic [LEN_W-1:0] RESET_TABLE_LEN    = 16'd512;
   localparam logic [LEN_W-1:0] RESET_X_AXIS_LEN   = 16'd32;
   localparam logic [LEN_W-1:0] RESET_Y_AXIS_LEN   = 16'd32;
   localparam logic [LEN_W-1:0] RESET_ANALOG_CNT   = 16'd8;

   localparam logic [7:0] CH_WR_TABLE   = 8'h56; // V
   localparam logic [7:0] CH_WR_SETTING = 8'h43; // C
   localparam logic [7:0] CH_WR_X_AXIS  = 8'h58; // X
   localparam logic [7:0] CH_WR_Y_AXIS  = 8'h59; // Y
   localparam logic [7:0] CH_RD_REALTIME = 8'h61; // a
   localparam logic [7:0] CH_RD_SETTINGS = 8'h63; // c
   localparam logic [7:0] CH_RD_TABLE    = 8'h76; // v
   localparam logic [7:0] CH_RD_X_AXIS   = 8'h78; // x
   localparam logic [7:0] CH_RD_Y_AXIS   = 8'h79; // y
   localparam logic [7:0] CH_RD_ANALOG   = 8'h72; // r
   localparam logic [7:0] CH_RD_STATUS   = 8'h73; // s
   localparam logic [7:0] CH_RD_DEBUG    = 8'h64; // d

   typedef logic [NUM_CSR-1:0][LEN_W-1:0] len_array_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [1:0]       write_target;
      logic [7:0]       offset_high;
      logic [7:0]       offset_low;
      logic [7:0]       write_value;
      logic [2:0]       source_id;
      logic [LEN_W-1:0] byte_index;
      logic             last_byte;
   } rsp_type;

   typedef struct packed {
      logic       wr_valid;
      logic [1:0] wr_target;
      logic [7:0] wr_offset_high;
      logic [7:0] wr_offset_low;
      logic [7:0] wr_value;
      logic       enq_valid;
      logic [2:0] enq_source;
   } parse_out_type;

   typedef struct packed {
      logic             fetch_valid;
      logic             drop;
      logic [2:0]       source;
      logic [LEN_W-1:0] index;
      logic             last;
   } queue_out_type;

endpackage

`default_nettype wire

@@ src/serial_command_parser_with_reply_queue.sv @@
// ----------------------------------------------------------------------------
// serial_command_parser_with_reply_queue
// Serial byte command parser with a reply request queue.
//
// req_*: one beat is a received byte (item_kind 0) or a transmitter-ready
//   tick (item_kind 1). Bytes with rx_error set are dropped silently.
// rsp_*: store writes, transmit fetches (source, byte index, last flag) and
//   queue-full drops. Beats that cause no result produce nothing on rsp_*.
// csr_*: length registers, always ready. The user must write them only while
//   the block is idle; the block itself does not enforce this.
// Path: input register, then result register, held there until rsp_ready.
// Throughput: one beat per cycle unless rsp_ready low holds a result; the
//   parser and queue pointers step per beat; the oldest entry is prefetched.
// Stall: while rsp_valid is held by rsp_ready low, one more beat is taken
//   into the input register, then req_ready drops until the result leaves.
// Reset: synchronous; parser idle, queue empty, lengths at defaults.
//   The queue storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module serial_command_parser_with_reply_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire scpr_pkg::req_type      req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output scpr_pkg::rsp_type           rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [15:0]            csr_data
);

   scpr_pkg::req_type       in_ff;
   logic                    in_valid_ff;
   scpr_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   scpr_pkg::len_array_type lengths_ff;

   scpr_pkg::parse_out_type parse_out;
   scpr_pkg::queue_out_type queue_out;

   logic advance;
   logic step_byte;
   logic step_tick;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign step_byte = advance && (in_ff.item_kind == scpr_pkg::KIND_BYTE) && !in_ff.rx_error;
   assign step_tick = advance && (in_ff.item_kind == scpr_pkg::KIND_TICK);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   scpr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step_byte),
      .rx_byte   (in_ff.rx_byte),
      .parse_out (parse_out)
   );

   scpr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .tick       (step_tick),
      .enq        (parse_out.enq_valid),
      .enq_source (parse_out.enq_source),
      .lengths    (lengths_ff),
      .queue_out  (queue_out)
   );

   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      if (parse_out.wr_valid) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_kind  = scpr_pkg::RESULT_WRITE;
         rsp_in.write_target = parse_out.wr_target;
         rsp_in.offset_high  = parse_out.wr_offset_high;
         rsp_in.offset_low   = parse_out.wr_offset_low;
         rsp_in.write_value  = parse_out.wr_value;
      end else if (queue_out.fetch_valid) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = scpr_pkg::RESULT_FETCH;
         rsp_in.source_id   = queue_out.source;
         rsp_in.byte_index  = queue_out.index;
         rsp_in.last_byte   = queue_out.last;
      end else if (queue_out.drop) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = scpr_pkg::RESULT_DROP;
         rsp_in.source_id   = queue_out.source;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lengths_ff[scpr_pkg::CSR_REALTIME_LEN] <= scpr_pkg::RESET_REALTIME_LEN;
         lengths_ff[scpr_pkg::CSR_SETTINGS_LEN] <= scpr_pkg::RESET_SETTINGS_LEN;
         lengths_ff[scpr_pkg::CSR_TABLE_LEN]    <= scpr_pkg::RESET_TABLE_LEN;
         lengths_ff[scpr_pkg::CSR_X_AXIS_LEN]   <= scpr_pkg::RESET_X_AXIS_LEN;
         lengths_ff[scpr_pkg::CSR_Y_AXIS_LEN]   <= scpr_pkg::RESET_Y_AXIS_LEN;
         lengths_ff[scpr_pkg::CSR_ANALOG_CNT]   <= scpr_pkg::RESET_ANALOG_CNT;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= rsp_valid_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               scpr_pkg::CSR_REALTIME_LEN,
               scpr_pkg::CSR_SETTINGS_LEN,
               scpr_pkg::CSR_TABLE_LEN,
               scpr_pkg::CSR_X_AXIS_LEN,
               scpr_pkg::CSR_Y_AXIS_LEN,
               scpr_pkg::CSR_ANALOG_CNT: lengths_ff[csr_index] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, !req_ready,
      in_valid_ff && rsp_valid_ff, "request stalled with a free stage")

endmodule

`default_nettype wire

@@ src/scpr_parser.sv @@
// ----------------------------------------------------------------------------
// scpr_parser
// Four-phase command parser: write commands and reply request letters.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             rx_byte,
   output scpr_pkg::parse_out_type     parse_out
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_OFF_HIGH,
      PH_OFF_LOW,
      PH_VALUE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [7:0] off_high_ff, off_high_in;
   logic [7:0] off_low_ff, off_low_in;

   always_comb begin
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      off_high_in = off_high_ff;
      off_low_in  = off_low_ff;
      parse_out   = '0;
      parse_out.wr_target      = cmd_ff;
      parse_out.wr_offset_high = off_high_ff;
      parse_out.wr_offset_low  = off_low_ff;
      parse_out.wr_value       = rx_byte;
      if (step) begin
         case (phase_ff)
            PH_OFF_HIGH: begin
               off_high_in = rx_byte;
               phase_in    = PH_OFF_LOW;
            end
            PH_OFF_LOW: begin
               off_low_in = rx_byte;
               phase_in   = PH_VALUE;
            end
            PH_VALUE: begin
               parse_out.wr_valid = 1'b1;
               phase_in           = PH_IDLE;
            end
            default: begin
               case (rx_byte)
                  scpr_pkg::CH_WR_TABLE: begin
                     cmd_in   = scpr_pkg::TARGET_TABLE;
                     phase_in = PH_OFF_HIGH;
                  end
                  scpr_pkg::CH_WR_SETTING: begin
                     cmd_in   = scpr_pkg::TARGET_SETTING;
                     phase_in = PH_OFF_HIGH;
                  end
                  scpr_pkg::CH_WR_X_AXIS: begin
                     cmd_in   = scpr_pkg::TARGET_X_AXIS;
                     phase_in = PH_OFF_HIGH;
                  end
                  scpr_pkg::CH_WR_Y_AXIS: begin
                     cmd_in   = scpr_pkg::TARGET_Y_AXIS;
                     phase_in = PH_OFF_HIGH;
                  end
                  scpr_pkg::CH_RD_REALTIME: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_REALTIME;
                  end
                  scpr_pkg::CH_RD_SETTINGS: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_SETTINGS;
                  end
                  scpr_pkg::CH_RD_TABLE: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_TABLE;
                  end
                  scpr_pkg::CH_RD_X_AXIS: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_X_AXIS;
                  end
                  scpr_pkg::CH_RD_Y_AXIS: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_Y_AXIS;
                  end
                  scpr_pkg::CH_RD_ANALOG: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_ANALOG;
                  end
                  scpr_pkg::CH_RD_STATUS: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_STATUS;
                  end
                  scpr_pkg::CH_RD_DEBUG: begin
                     parse_out.enq_valid  = 1'b1;
                     parse_out.enq_source = scpr_pkg::SRC_DEBUG;
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cmd_ff      <= scpr_pkg::TARGET_TABLE;
         off_high_ff <= '0;
         off_low_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         cmd_ff      <= cmd_in;
         off_high_ff <= off_high_in;
         off_low_ff  <= off_low_in;
      end
   end

endmodule

`default_nettype wire

@@ src/scpr_queue.sv @@
// ----------------------------------------------------------------------------
// scpr_queue
// Reply request queue: enqueues requests, steps byte indexes on each tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scpr_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick,
   input  wire logic                          enq,
   input  wire logic [2:0]                    enq_source,
   input  wire scpr_pkg::len_array_type       lengths,
   output scpr_pkg::queue_out_type            queue_out
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ENTRY_W = 3 + scpr_pkg::LEN_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [scpr_pkg::LEN_W-1:0] index_ff, index_in;

   logic [PTR_W-1:0]           head_next;
   logic [PTR_W-1:0]           tail_next;
   logic                       empty;
   logic                       full;
   logic                       do_write;
   logic                       last;
   logic [scpr_pkg::LEN_W-1:0] len;
   logic [scpr_pkg::LEN_W-1:0] last_index;
   logic [scpr_pkg::LEN_W-1:0] head_index;
   logic [2:0]                 head_source;

   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
   assign empty     = (head_ff == tail_ff);
   assign full      = (head_next == tail_ff);
   assign do_write  = enq && !full;

   assign head_source = rd_ff[ENTRY_W-1 -: 3];
   assign head_index  = rd_ff[scpr_pkg::LEN_W-1:0];
   assign last        = (index_ff >= head_index);

   always_comb begin
      case (enq_source)
         scpr_pkg::SRC_REALTIME: len = lengths[scpr_pkg::CSR_REALTIME_LEN];
         scpr_pkg::SRC_SETTINGS: len = lengths[scpr_pkg::CSR_SETTINGS_LEN];
         scpr_pkg::SRC_TABLE:    len = lengths[scpr_pkg::CSR_TABLE_LEN];
         scpr_pkg::SRC_X_AXIS:   len = lengths[scpr_pkg::CSR_X_AXIS_LEN];
         scpr_pkg::SRC_Y_AXIS:   len = lengths[scpr_pkg::CSR_Y_AXIS_LEN];
         scpr_pkg::SRC_ANALOG:   len = lengths[scpr_pkg::CSR_ANALOG_CNT];
         default:                len = scpr_pkg::LEN_W'(1);
      endcase
      last_index = (len == '0) ? '0 : len - 1'b1;
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      index_in  = index_ff;
      queue_out = '0;
      if (tick && !empty) begin
         queue_out.fetch_valid = 1'b1;
         queue_out.source      = head_source;
         queue_out.index       = index_ff;
         queue_out.last        = last;
         if (last) begin
            index_in = '0;
            tail_in  = tail_next;
         end else begin
            index_in = index_ff + 1'b1;
         end
      end
      if (enq) begin
         if (full) begin
            queue_out.drop   = 1'b1;
            queue_out.source = enq_source;
         end else begin
            head_in = head_next;
            if (empty) begin
               index_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         index_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         index_ff <= index_in;
      end
   end

   // oldest entry prefetched; write-first when the slot is written this beat
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[head_ff] <= {enq_source, last_index};
      end
      if (do_write && (head_ff == tail_in)) begin
         rd_ff <= {enq_source, last_index};
      end else begin
         rd_ff <= mem[tail_in];
      end
   end

   `ASSERT_NEXT(a_enq_not_empty, clock, reset, do_write, head_ff != tail_ff,
      "queue empty after enqueue")
   `ASSERT_IMPLY(a_idle_index_zero, clock, reset, empty, index_ff == '0,
      "byte index nonzero with empty queue")

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_command_parser_with_reply_queue.
//
// Received bytes and transmit ticks are queued up by a stimulus process and
// sent by a bursty driver. Each accepted beat runs through a local copy of
// the parser and reply queue, and any result it should cause is queued up.
// The monitor checks every result beat, field by field, against the oldest
// queued result. Lengths are written between phases, once the block is idle.
// ----------------------------------------------------------------------------

module tb;

   localparam int QDEPTH = 8;
   localparam int LIMIT  = 2000000;
   localparam int SETTLE = 6;

   typedef enum logic [1:0] {PH_IDLE, PH_OFS_HI, PH_OFS_LO, PH_VALUE} parse_phase_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   scpr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   scpr_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [15:0]       csr_data = '0;

   // local copy of the block's state
   parse_phase_type parse_phase = PH_IDLE;
   logic [1:0]  pend_target = scpr_pkg::TARGET_TABLE;
   logic [7:0]  held_hi = '0;
   logic [7:0]  held_lo = '0;
   logic [2:0]  q_src [QDEPTH];
   logic [15:0] q_last [QDEPTH];
   logic [15:0] cur_idx = '0;
   int          q_head = 0;
   int          q_tail = 0;
   logic [15:0] len_reg [scpr_pkg::NUM_CSR];

   scpr_pkg::req_type pending_beats [$];
   scpr_pkg::rsp_type expected_results [$];
   int          queued_count = 0;
   int          taken_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          write_count = 0;
   int          fetch_count = 0;
   int          drop_count = 0;
   int          last_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          hold_left = 0;
   int          pat_left = 0;
   int          pat_mode = 0;
   int          holds_asked = 0;
   int          holds_done = 0;

   serial_command_parser_with_reply_queue #(
      .QUEUE_DEPTH(QDEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // 0..3 write commands, 4..11 reply letters
   function automatic logic [7:0] command_char(input int i);
      case (i)
         0:       return scpr_pkg::CH_WR_TABLE;
         1:       return scpr_pkg::CH_WR_SETTING;
         2:       return scpr_pkg::CH_WR_X_AXIS;
         3:       return scpr_pkg::CH_WR_Y_AXIS;
         4:       return scpr_pkg::CH_RD_REALTIME;
         5:       return scpr_pkg::CH_RD_SETTINGS;
         6:       return scpr_pkg::CH_RD_TABLE;
         7:       return scpr_pkg::CH_RD_X_AXIS;
         8:       return scpr_pkg::CH_RD_Y_AXIS;
         9:       return scpr_pkg::CH_RD_ANALOG;
         10:      return scpr_pkg::CH_RD_STATUS;
         default: return scpr_pkg::CH_RD_DEBUG;
      endcase
   endfunction

   // advances the local state by one accepted beat; 1 if a result follows
   function automatic bit step_parser(input scpr_pkg::req_type it,
                                      output scpr_pkg::rsp_type res);
      logic [2:0]  src;
      logic [15:0] len;
      int          nxt;
      res = '0;
      if (it.item_kind == scpr_pkg::KIND_TICK) begin
         if (q_head == q_tail) return 1'b0;
         res.result_kind = scpr_pkg::RESULT_FETCH;
         res.source_id = q_src[q_tail];
         res.byte_index = cur_idx;
         res.last_byte = (cur_idx >= q_last[q_tail]);
         if (res.last_byte) begin
            cur_idx = '0;
            q_tail = (q_tail + 1) % QDEPTH;
         end else begin
            cur_idx = cur_idx + 16'd1;
         end
         return 1'b1;
      end
      if (it.rx_error) return 1'b0;
      case (parse_phase)
         PH_OFS_HI: begin
            held_hi = it.rx_byte;
            parse_phase = PH_OFS_LO;
            return 1'b0;
         end
         PH_OFS_LO: begin
            held_lo = it.rx_byte;
            parse_phase = PH_VALUE;
            return 1'b0;
         end
         PH_VALUE: begin
            parse_phase = PH_IDLE;
            res.result_kind = scpr_pkg::RESULT_WRITE;
            res.write_target = pend_target;
            res.offset_high = held_hi;
            res.offset_low = held_lo;
            res.write_value = it.rx_byte;
            return 1'b1;
         end
         default: ;
      endcase
      case (it.rx_byte)
         scpr_pkg::CH_WR_TABLE: begin
            pend_target = scpr_pkg::TARGET_TABLE;
            parse_phase = PH_OFS_HI;
            return 1'b0;
         end
         scpr_pkg::CH_WR_SETTING: begin
            pend_target = scpr_pkg::TARGET_SETTING;
            parse_phase = PH_OFS_HI;
            return 1'b0;
         end
         scpr_pkg::CH_WR_X_AXIS: begin
            pend_target = scpr_pkg::TARGET_X_AXIS;
            parse_phase = PH_OFS_HI;
            return 1'b0;
         end
         scpr_pkg::CH_WR_Y_AXIS: begin
            pend_target = scpr_pkg::TARGET_Y_AXIS;
            parse_phase = PH_OFS_HI;
            return 1'b0;
         end
         scpr_pkg::CH_RD_REALTIME: begin
            src = scpr_pkg::SRC_REALTIME;
            len = len_reg[scpr_pkg::CSR_REALTIME_LEN];
         end
         scpr_pkg::CH_RD_SETTINGS: begin
            src = scpr_pkg::SRC_SETTINGS;
            len = len_reg[scpr_pkg::CSR_SETTINGS_LEN];
         end
         scpr_pkg::CH_RD_TABLE: begin
            src = scpr_pkg::SRC_TABLE;
            len = len_reg[scpr_pkg::CSR_TABLE_LEN];
         end
         scpr_pkg::CH_RD_X_AXIS: begin
            src = scpr_pkg::SRC_X_AXIS;
            len = len_reg[scpr_pkg::CSR_X_AXIS_LEN];
         end
         scpr_pkg::CH_RD_Y_AXIS: begin
            src = scpr_pkg::SRC_Y_AXIS;
            len = len_reg[scpr_pkg::CSR_Y_AXIS_LEN];
         end
         scpr_pkg::CH_RD_ANALOG: begin
            src = scpr_pkg::SRC_ANALOG;
            len = len_reg[scpr_pkg::CSR_ANALOG_CNT];
         end
         scpr_pkg::CH_RD_STATUS: begin
            src = scpr_pkg::SRC_STATUS;
            len = 16'd1;
         end
         scpr_pkg::CH_RD_DEBUG: begin
            src = scpr_pkg::SRC_DEBUG;
            len = 16'd1;
         end
         default: return 1'b0;
      endcase
      nxt = (q_head + 1) % QDEPTH;
      if (nxt == q_tail) begin
         res.result_kind = scpr_pkg::RESULT_DROP;
         res.source_id = src;
         return 1'b1;
      end
      if (len != 16'd0) len = len - 16'd1;
      q_src[q_head] = src;
      q_last[q_head] = len;
      if (q_head == q_tail) cur_idx = '0;
      q_head = nxt;
      return 1'b0;
   endfunction

   task automatic add_item(input logic kind, input logic [7:0] b, input logic err);
      scpr_pkg::req_type it;
      it.item_kind = kind;
      it.rx_byte = b;
      it.rx_error = err;
      pending_beats.push_back(it);
      queued_count++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (taken_count != queued_count || expected_results.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // ticks until every queued reply has sent its last byte
   task automatic drain_reply_queue();
      int n;
      int p;
      n = 0;
      for (p = q_tail; p != q_head; p = (p + 1) % QDEPTH) n += int'(q_last[p]) + 1;
      n -= int'(cur_idx);
      repeat (n)
         add_item(scpr_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      len_reg[idx] = val;
      csr_valid <= 1'b0;
   endtask

   task automatic set_lengths(input logic [15:0] rt, input logic [15:0] st,
                              input logic [15:0] tv, input logic [15:0] xa,
                              input logic [15:0] ya, input logic [15:0] an);
      write_reg(scpr_pkg::CSR_REALTIME_LEN, rt);
      write_reg(scpr_pkg::CSR_SETTINGS_LEN, st);
      write_reg(scpr_pkg::CSR_TABLE_LEN, tv);
      write_reg(scpr_pkg::CSR_X_AXIS_LEN, xa);
      write_reg(scpr_pkg::CSR_Y_AXIS_LEN, ya);
      write_reg(scpr_pkg::CSR_ANALOG_CNT, an);
   endtask

   function automatic logic [15:0] rand_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 16'd0;
      if (r < 8) return 16'($urandom_range(1, 4));
      return 16'($urandom_range(5, 40));
   endfunction

   task automatic add_random_unit();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         add_item(scpr_pkg::KIND_BYTE, command_char($urandom_range(0, 3)), 1'b0);
         repeat (3) begin
            if ($urandom_range(0, 9) == 0)
               add_item(scpr_pkg::KIND_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 4) == 0)
               add_item(scpr_pkg::KIND_BYTE, command_char($urandom_range(0, 11)), 1'b0);
            else
               add_item(scpr_pkg::KIND_BYTE, 8'($urandom_range(0, 255)), 1'b0);
         end
      end else if (pick < 60) begin
         add_item(scpr_pkg::KIND_BYTE, command_char($urandom_range(4, 11)), 1'b0);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 4))
            add_item(scpr_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else begin
         add_item(scpr_pkg::KIND_BYTE, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin : drive_proc
      scpr_pkg::rsp_type res;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (step_parser(req_data, res)) expected_results.push_back(res);
            taken_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pending_beats.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: stall patterns, rare long holds, and requested long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         pat_left = 0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = 250;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_mode = $urandom_range(0, 3);
            pat_left = $urandom_range(5, 60);
            if ($urandom_range(0, 49) == 0) hold_left = $urandom_range(40, 120);
         end
         pat_left--;
         case (pat_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= ($urandom_range(0, 4) != 0);
            default: rsp_ready <= (pat_left % 3 != 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin : check_proc
      scpr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with none expected: %h", rsp_data);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("result_kind", 16'(want.result_kind), 16'(rsp_data.result_kind));
            check_field("write_target", 16'(want.write_target),
                        16'(rsp_data.write_target));
            check_field("offset_high", 16'(want.offset_high), 16'(rsp_data.offset_high));
            check_field("offset_low", 16'(want.offset_low), 16'(rsp_data.offset_low));
            check_field("write_value", 16'(want.write_value), 16'(rsp_data.write_value));
            check_field("source_id", 16'(want.source_id), 16'(rsp_data.source_id));
            check_field("byte_index", want.byte_index, rsp_data.byte_index);
            check_field("last_byte", 16'(want.last_byte), 16'(rsp_data.last_byte));
            case (want.result_kind)
               scpr_pkg::RESULT_WRITE: write_count++;
               scpr_pkg::RESULT_FETCH: fetch_count++;
               default:                drop_count++;
            endcase
            if (want.last_byte) last_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      int target;
      len_reg[scpr_pkg::CSR_REALTIME_LEN] = scpr_pkg::RESET_REALTIME_LEN;
      len_reg[scpr_pkg::CSR_SETTINGS_LEN] = scpr_pkg::RESET_SETTINGS_LEN;
      len_reg[scpr_pkg::CSR_TABLE_LEN] = scpr_pkg::RESET_TABLE_LEN;
      len_reg[scpr_pkg::CSR_X_AXIS_LEN] = scpr_pkg::RESET_X_AXIS_LEN;
      len_reg[scpr_pkg::CSR_Y_AXIS_LEN] = scpr_pkg::RESET_Y_AXIS_LEN;
      len_reg[scpr_pkg::CSR_ANALOG_CNT] = scpr_pkg::RESET_ANALOG_CNT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: errored bytes, empty-queue tick, writes, letters as data
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_WR_TABLE, 1'b1);
      add_item(scpr_pkg::KIND_TICK, 8'hFF, 1'b1);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_WR_TABLE, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_WR_Y_AXIS, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_WR_SETTING, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'h5A, 1'b1);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_RD_REALTIME, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'hFF, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_WR_X_AXIS, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'h01, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'hFE, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_WR_TABLE, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, 8'hFF, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_RD_STATUS, 1'b0);
      add_item(scpr_pkg::KIND_TICK, 8'h00, 1'b0);
      wait_drained();
      drain_reply_queue();

      // zero lengths, every reply letter, last one hits a full queue
      set_lengths(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      for (int i = 4; i < 12; i++) add_item(scpr_pkg::KIND_BYTE, command_char(i), 1'b0);
      wait_drained();
      drain_reply_queue();

      // long reply followed by a one-byte reply
      set_lengths(16'd64, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_RD_REALTIME, 1'b0);
      add_item(scpr_pkg::KIND_BYTE, scpr_pkg::CH_RD_DEBUG, 1'b0);
      wait_drained();
      drain_reply_queue();

      for (int ph = 0; ph < 8; ph++) begin
         set_lengths(rand_len(), rand_len(), rand_len(), rand_len(), rand_len(), rand_len());
         if (ph == 1) holds_asked++;
         target = queued_count + 120;
         while (queued_count < target) add_random_unit();
         wait_drained();
         drain_reply_queue();
      end

      repeat (SETTLE) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end
      $display("%0d beats sent: %0d writes, %0d fetches (%0d replies done), %0d drops",
               taken_count, write_count, fetch_count, last_count, drop_count);
      $display("lengths from 0 to 64, full-queue drops, receiver holds and stalls");
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
